>>> rtl/mbrq_pkg.sv
`default_nettype none
package mbrq_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned BLOCK_MAX = 64;
  localparam int unsigned ELEM_BITS = 8;
  localparam int unsigned QDEPTH    = 2;

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned IDX_W   = $clog2(BLOCK_MAX);
  localparam int unsigned ADDR_W  = SLOT_W + IDX_W;
  localparam int unsigned HELD_W  = $clog2(SLOTS + 1);
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned BE_W    = 7;
  localparam int unsigned POOL_W  = 4;
  localparam int unsigned CMP_W   = (HELD_W > POOL_W) ? HELD_W : POOL_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ELEMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS    = 2'd1;

  localparam logic [BE_W-1:0]   BE_RESET   = 7'd64;
  localparam logic [POOL_W-1:0] POOL_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_COMMIT = 3'd1,
    ST_NOBLK  = 3'd2,
    ST_LONG   = 3'd3,
    ST_READ   = 3'd4,
    ST_EMPTY  = 3'd5
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] data_in;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              last_out;
    logic [2:0]        status;
    logic [LEN_W-1:0]  msg_length;
  } out_item_t;

  // classified item as held in the front queue
  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
    logic              last;
  } op_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  bsize;
    logic [POOL_W-1:0] pool;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/mbrq_front.sv
`default_nettype none
module mbrq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mbrq_pkg::in_item_t  in_data_i,
  output logic                head_valid_o,
  input  logic                head_ready_i,
  output mbrq_pkg::op_item_t  head_o
);
  import mbrq_pkg::*;

  op_item_t            entry_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                push, pop;
  op_item_t            item;

  assign in_ready_o   = (count_q != QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = head_valid_o && head_ready_i;

  always_comb begin
    item.op   = op_e'(in_data_i.req_type);
    item.data = in_data_i.data_in;
    item.last = in_data_i.last_in;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mbrq_back.sv
`default_nettype none
module mbrq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbrq_pkg::cfg_t      cfg_i,
  input  logic                head_valid_i,
  output logic                head_ready_o,
  input  mbrq_pkg::op_item_t  head_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mbrq_pkg::out_item_t out_data_o
);
  import mbrq_pkg::*;

  // element store, one block per slot
  logic [ELEM_BITS-1:0] mem [SLOTS * BLOCK_MAX];
  logic [ELEM_BITS-1:0] rd_data_q;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;

  logic [LEN_W-1:0]  slot_len_q [SLOTS];
  logic [SLOTS-1:0]  occ_q, occ_d;
  logic [SLOT_W-1:0] ws_q, ws_d, rs_q, rs_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic              drop_q, drop_d;
  logic [HELD_W-1:0] held_q, held_d;

  logic              busy_q, busy_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              out_free, adv, start, burst_issue, direct_load;
  logic              first, new_drop, commit, free_slot;
  logic [LEN_W-1:0]  rd_len;

  assign out_free    = !out_valid_q || out_ready_i;
  assign adv         = pend_q && out_free;
  assign start       = head_valid_i && !busy_q && !pend_q && out_free;
  assign burst_issue = busy_q && (!pend_q || adv);
  assign head_ready_o = start;
  assign rd_len      = slot_len_q[rs_q];

  assign first    = !drop_q && (fill_q == '0);
  assign new_drop = drop_q
                 || (first && (occ_q[ws_q] || (CMP_W'(held_q) >= CMP_W'(cfg_i.pool))))
                 || (!first && (fill_q >= cfg_i.bsize));

  always_comb begin
    occ_d       = occ_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    fill_d      = fill_q;
    drop_d      = drop_q;
    held_d      = held_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    len_d       = len_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = {ws_q, fill_q[IDX_W-1:0]};
    mem_raddr   = {rs_q, idx_q};
    commit      = 1'b0;
    free_slot   = 1'b0;
    direct_load = 1'b0;

    if (adv) begin
      pend_d      = 1'b0;
      out_valid_d = 1'b1;
      out_d.data_out   = rd_data_q;
      out_d.last_out   = pend_last_q;
      out_d.status     = ST_READ;
      out_d.msg_length = len_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (start && head_i.op == OP_WRITE) begin
      direct_load      = 1'b1;
      out_d.data_out   = '0;
      out_d.last_out   = 1'b1;
      out_d.msg_length = '0;
      if (new_drop) begin
        out_d.status = (fill_q != '0) ? ST_LONG : ST_NOBLK;
        if (head_i.last) begin
          drop_d = 1'b0;
          fill_d = '0;
        end else begin
          drop_d = 1'b1;
        end
      end else begin
        mem_we = 1'b1;
        if (head_i.last) begin
          commit           = 1'b1;
          out_d.status     = ST_COMMIT;
          out_d.msg_length = fill_q + 1'b1;
          occ_d[ws_q]      = 1'b1;
          held_d           = held_q + 1'b1;
          ws_d             = (ws_q == SLOT_W'(SLOTS - 1)) ? '0 : ws_q + 1'b1;
          fill_d           = '0;
        end else begin
          out_d.status = ST_ACCEPT;
          fill_d       = fill_q + 1'b1;
        end
      end
    end else if (start && head_i.op == OP_READ) begin
      if (!occ_q[rs_q]) begin
        direct_load      = 1'b1;
        out_d.data_out   = '0;
        out_d.last_out   = 1'b1;
        out_d.status     = ST_EMPTY;
        out_d.msg_length = '0;
      end else begin
        // the first element is read from memory with the pop
        mem_re      = 1'b1;
        mem_raddr   = {rs_q, {IDX_W{1'b0}}};
        pend_d      = 1'b1;
        len_d       = rd_len;
        pend_last_d = (rd_len == LEN_W'(1));
        if (rd_len == LEN_W'(1)) begin
          free_slot = 1'b1;
        end else begin
          busy_d = 1'b1;
          idx_d  = IDX_W'(1);
        end
      end
    end else if (burst_issue) begin
      mem_re      = 1'b1;
      pend_d      = 1'b1;
      pend_last_d = (LEN_W'(idx_q) == len_q - 1'b1);
      if (LEN_W'(idx_q) == len_q - 1'b1) begin
        free_slot = 1'b1;
        busy_d    = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (direct_load) begin
      out_valid_d = 1'b1;
    end

    if (free_slot) begin
      occ_d[rs_q] = 1'b0;
      if (held_q != '0) begin
        held_d = held_q - 1'b1;
      end
      rs_d = (rs_q == SLOT_W'(SLOTS - 1)) ? '0 : rs_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      ws_q        <= '0;
      rs_q        <= '0;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      held_q      <= '0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      ws_q        <= ws_d;
      rs_q        <= rs_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      held_q      <= held_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q       <= len_d;
    pend_last_q <= pend_last_d;
    out_q       <= out_d;
    if (commit) begin
      slot_len_q[ws_q] <= fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= head_i.data[ELEM_BITS-1:0];
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_held_matches_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == HELD_W'($countones(occ_q)))
    else $error("blocks held out of step with occupied slots");

  a_direct_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    direct_load |-> !pend_q && !busy_q)
    else $error("direct result collides with read stream");

  a_busy_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> occ_q[rs_q] && (LEN_W'(idx_q) < len_q))
    else $error("read burst on a free slot or past its length");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LEN_W'(BLOCK_MAX))
    else $error("fill count beyond block size");

endmodule
`default_nettype wire

>>> rtl/message_block_ring_queue_unit.sv
`default_nettype none
// Ring of 8 message slots, each holding one block of up to 64 byte elements.
// A write item carries one element and last_in commits the message; a message
// that finds its slot busy or the block pool used up is dropped whole with a
// no-free-block status, one that outgrows block_elements with a too-long
// status. A read item streams the oldest message, one result per element,
// and frees its slot. Items pass a two-entry front queue and are then carried
// out in order by the back end. A write or an empty read gives one result; a
// read of an n-element message reads the single element memory once per
// element and stalls while the output is held. Element storage needs no
// clearing after reset: only committed elements are read back.
// Configuration writes are always ready and are to be issued while idle.
module message_block_ring_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mbrq_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mbrq_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mbrq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mbrq_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mbrq_pkg::*;

  logic [BE_W-1:0]   be_q;
  logic [POOL_W-1:0] pool_q;
  cfg_t              cfg;
  logic              head_valid, head_ready;
  op_item_t          head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q   <= BE_RESET;
      pool_q <= POOL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BLOCK_ELEMENTS: be_q   <= cfg_data_i[BE_W-1:0];
        CFG_POOL_BLOCKS:    pool_q <= cfg_data_i[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp block size to one block; zero counts as one element
  always_comb begin
    if (be_q == '0) begin
      cfg.bsize = LEN_W'(1);
    end else if (LEN_W'(be_q) > LEN_W'(BLOCK_MAX)) begin
      cfg.bsize = LEN_W'(BLOCK_MAX);
    end else begin
      cfg.bsize = LEN_W'(be_q);
    end
    cfg.pool = pool_q;
  end

  mbrq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_ready_i (head_ready),
    .head_o       (head)
  );

  mbrq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .head_i       (head),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire
